/* design/pps_pkg.sv */
// ----------------------------------------------------------------------------
// pps_pkg: shared types and constants of the piecewise polynomial sampler
// Holds the store sizes, command and result structs, state and opcode enums,
// and the 48-bit saturation helper used by the arithmetic unit.
// ----------------------------------------------------------------------------
package pps_pkg;

	// Store sizes.
	localparam int MAX_SEGMENTS = 16;
	localparam int NUM_COEFFS   = 8;
	localparam int NUM_AXES     = 3;
	localparam int SEG_W        = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int SEGC_W       = $clog2(MAX_SEGMENTS + 1);
	localparam int TERM_W       = $clog2(NUM_COEFFS);
	localparam int COEF_DEPTH   = NUM_AXES * MAX_SEGMENTS * NUM_COEFFS;
	localparam int COEF_AW      = $clog2(COEF_DEPTH);

	// Fixed-point widths.
	localparam int VAL_W  = 48;
	localparam int TIME_W = 24;
	localparam int HALF_W = TIME_W / 2;
	localparam int ACC_W  = VAL_W + TIME_W;
	localparam int PROD_W = VAL_W + HALF_W + 1;
	localparam int SUM_W  = TIME_W + SEG_W;
	localparam int FRAC_W = 16;

	// Configuration register indexes.
	localparam logic [1:0] CFG_SEGMENT_COUNT  = 2'd0;
	localparam logic [1:0] CFG_TOTAL_DURATION = 2'd1;
	localparam logic [1:0] CFG_TRAJ_READY     = 2'd2;

	typedef enum logic [1:0] {
		FUNC_COEF     = 2'd0,
		FUNC_DURATION = 2'd1,
		FUNC_ENDPOINT = 2'd2,
		FUNC_SAMPLE   = 2'd3
	} func_t;

	typedef struct packed {
		func_t              func;
		logic [1:0]         axis;
		logic [3:0]         segment_index;
		logic [2:0]         term_index;
		logic               endpoint_select;
		logic signed [47:0] load_value;
		logic [23:0]        sample_time;
	} pps_cmd_t;

	typedef struct packed {
		logic signed [47:0] pos_x;
		logic signed [47:0] pos_y;
		logic signed [47:0] pos_z;
		logic signed [47:0] vel_x;
		logic signed [47:0] vel_y;
		logic signed [47:0] vel_z;
		logic               sample_ok;
		logic               saturated;
	} pps_result_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE, ST_SEARCH, ST_CLAMP,
		ST_P_RD, ST_P_INIT, ST_P_HI, ST_P_LO, ST_P_ADD,
		ST_V_RD, ST_V_INIT, ST_V_HI, ST_V_LO, ST_V_SC, ST_V_ADD, ST_V_END,
		ST_DONE
	} state_t;

	// Arithmetic unit operations.
	typedef enum logic [2:0] {
		MAC_IDLE, MAC_LOAD, MAC_SCALE_W, MAC_SCALE_S,
		MAC_HI, MAC_LO, MAC_ADD_C, MAC_ADD_S
	} mac_op_t;

	typedef struct packed {
		mac_op_t             op;
		logic [HALF_W-1:0]   b;
		logic                clr_flag;
	} mac_ctrl_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] val;
		logic                    hit;
	} sat_t;

	// Clip a wide signed value to the 48-bit range.
	function automatic sat_t sat48(input logic signed [PROD_W-1:0] x);
		sat_t r;
		logic signed [PROD_W-1:0] hi;
		logic signed [PROD_W-1:0] lo;
		hi = PROD_W'({1'b0, {(VAL_W-1){1'b1}}});
		lo = -hi - PROD_W'(1);
		if (x > hi) begin
			r.val = {1'b0, {(VAL_W-1){1'b1}}};
			r.hit = 1'b1;
		end else if (x < lo) begin
			r.val = {1'b1, {(VAL_W-1){1'b0}}};
			r.hit = 1'b1;
		end else begin
			r.val = x[VAL_W-1:0];
			r.hit = 1'b0;
		end
		return r;
	endfunction

endpackage

/* design/pps_coef_ram.sv */
// ----------------------------------------------------------------------------
// pps_coef_ram: coefficient memory
// One write port and one registered read port over all axis, segment and term
// entries.
// ----------------------------------------------------------------------------
module pps_coef_ram (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [pps_pkg::COEF_AW-1:0]           waddr,
	input  logic signed [pps_pkg::VAL_W-1:0]      wdata,
	input  logic                                  re,
	input  logic [pps_pkg::COEF_AW-1:0]           raddr,
	output logic signed [pps_pkg::VAL_W-1:0]      rdata
);

	logic signed [pps_pkg::VAL_W-1:0] mem [pps_pkg::COEF_DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* design/pps_mac_unit.sv */
// ----------------------------------------------------------------------------
// pps_mac_unit: shared multiply-accumulate unit
// One 48 by 12 bit multiplier with a 72-bit accumulator, a working register
// for the Horner value and a sticky saturation flag.
// ----------------------------------------------------------------------------
module pps_mac_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pps_pkg::mac_ctrl_t                ctrl,
	input  logic signed [pps_pkg::VAL_W-1:0]  a,
	output logic signed [pps_pkg::VAL_W-1:0]  w,
	output logic                              flag
);

	logic signed [pps_pkg::VAL_W-1:0]  w_q;
	logic signed [pps_pkg::VAL_W-1:0]  s_q;
	logic signed [pps_pkg::ACC_W-1:0]  acc_q;
	logic                              flag_q;

	logic signed [pps_pkg::VAL_W-1:0]  mul_a;
	logic signed [pps_pkg::HALF_W:0]   mul_b;
	logic signed [pps_pkg::PROD_W-1:0] prod;
	logic signed [pps_pkg::VAL_W-1:0]  addend;
	logic signed [pps_pkg::ACC_W-pps_pkg::FRAC_W:0] sum;
	pps_pkg::sat_t                     prod_sat;
	pps_pkg::sat_t                     sum_sat;
	logic                              hit;

	// Multiplier operands: the Horner value during time steps, else the input.
	always_comb begin
		mul_a = ((ctrl.op == pps_pkg::MAC_HI) || (ctrl.op == pps_pkg::MAC_LO)) ? w_q : a;
		mul_b = {1'b0, ctrl.b};
		prod  = mul_a * mul_b;
	end

	// Rounded product plus addend, then clipping.
	always_comb begin
		addend   = (ctrl.op == pps_pkg::MAC_ADD_S) ? s_q : a;
		sum      = (pps_pkg::ACC_W-pps_pkg::FRAC_W+1)'(
		               $signed(acc_q[pps_pkg::ACC_W-1:pps_pkg::FRAC_W]))
		         + (pps_pkg::ACC_W-pps_pkg::FRAC_W+1)'(addend);
		prod_sat = pps_pkg::sat48(prod);
		sum_sat  = pps_pkg::sat48(pps_pkg::PROD_W'(sum));
		unique case (ctrl.op)
			pps_pkg::MAC_SCALE_W, pps_pkg::MAC_SCALE_S: hit = prod_sat.hit;
			pps_pkg::MAC_ADD_C, pps_pkg::MAC_ADD_S:     hit = sum_sat.hit;
			default:                                    hit = 1'b0;
		endcase
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			pps_pkg::MAC_LOAD:    w_q <= a;
			pps_pkg::MAC_SCALE_W: w_q <= prod_sat.val;
			pps_pkg::MAC_SCALE_S: s_q <= prod_sat.val;
			pps_pkg::MAC_HI:      acc_q <= {prod[pps_pkg::ACC_W-pps_pkg::HALF_W-1:0],
			                                {pps_pkg::HALF_W{1'b0}}};
			pps_pkg::MAC_LO:      acc_q <= acc_q + pps_pkg::ACC_W'(prod)
			                               + pps_pkg::ACC_W'(1 << (pps_pkg::FRAC_W - 1));
			pps_pkg::MAC_ADD_C,
			pps_pkg::MAC_ADD_S:   w_q <= sum_sat.val;
			default: begin
			end
		endcase
	end

	// Sticky saturation flag, cleared when a transaction is accepted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b0;
		end else if (ctrl.clr_flag) begin
			flag_q <= 1'b0;
		end else if (hit) begin
			flag_q <= 1'b1;
		end
	end

	assign w    = w_q;
	assign flag = flag_q;

endmodule

/* design/piecewise_polynomial_sampler.sv */
// ----------------------------------------------------------------------------
// piecewise_polynomial_sampler: three-axis trajectory sampler
// Stores segment coefficients, durations and endpoints, and returns position
// and velocity per axis at a requested time.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Load commands
// (coefficient, duration, endpoint) finish in the accepting cycle and give no
// result. A sample command gives one result, shown on result for the single
// cycle in which done is high; the receiver cannot stall it. A sample that
// falls on an endpoint, or one issued while the trajectory is not ready or
// has no segments, goes from idle straight to done. An interior sample walks
// the segment durations one per cycle and then runs Horner's rule for each
// axis on one shared 48x12 multiplier, two passes per time multiply. The
// multiplier and the single read port of the coefficient memory are shared
// by all axes and terms, so these are worked one after another.
// ----------------------------------------------------------------------------
module piecewise_polynomial_sampler (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  pps_pkg::pps_cmd_t    cmd,
	output logic                 done,
	output pps_pkg::pps_result_t result,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [23:0]          cfg_data
);

	pps_pkg::state_t state_q, state_d;

	logic [4:0]                       seg_count_q;
	logic [pps_pkg::TIME_W-1:0]       total_q;
	logic                             ready_q;

	logic [pps_pkg::TIME_W-1:0]       dur_q [pps_pkg::MAX_SEGMENTS];
	logic signed [pps_pkg::VAL_W-1:0] endp_q [2*pps_pkg::NUM_AXES];

	logic [1:0]                       axis_q;
	logic [pps_pkg::TERM_W-1:0]       term_q;
	logic [pps_pkg::SEG_W-1:0]        idx_q;
	logic [pps_pkg::SEG_W-1:0]        found_q;
	logic [pps_pkg::SEGC_W-1:0]       n_q;
	logic [pps_pkg::SUM_W-1:0]        accum_q;
	logic [pps_pkg::TIME_W-1:0]       t_q;
	logic [pps_pkg::TIME_W-1:0]       local_q;
	pps_pkg::pps_result_t             res_q;

	logic                             accept;
	logic [pps_pkg::SEG_W-1:0]        dur_addr;
	logic [pps_pkg::TIME_W-1:0]       dur_rd;
	logic [pps_pkg::SUM_W-1:0]        dur_sum;
	logic                             hit_seg;
	logic                             last_seg;
	logic [pps_pkg::SEGC_W-1:0]       n_lim;

	logic                             ram_we;
	logic [pps_pkg::COEF_AW-1:0]      ram_waddr;
	logic                             ram_re;
	logic [pps_pkg::TERM_W-1:0]       rd_term;
	logic [pps_pkg::COEF_AW-1:0]      ram_raddr;
	logic signed [pps_pkg::VAL_W-1:0] ram_rdata;

	pps_pkg::mac_ctrl_t               mac_ctrl;
	logic signed [pps_pkg::VAL_W-1:0] mac_w;
	logic                             mac_flag;

	assign accept = start && (state_q == pps_pkg::ST_IDLE);

	// Segment search: one duration per cycle against the running sum.
	always_comb begin
		dur_addr = (state_q == pps_pkg::ST_CLAMP) ? found_q : idx_q;
		dur_rd   = dur_q[dur_addr];
		dur_sum  = accum_q + pps_pkg::SUM_W'(dur_rd);
		hit_seg  = pps_pkg::SUM_W'(t_q) < dur_sum;
		last_seg = pps_pkg::SEGC_W'(idx_q) == n_q - pps_pkg::SEGC_W'(1);
		n_lim    = (seg_count_q > 5'(pps_pkg::MAX_SEGMENTS))
		         ? pps_pkg::SEGC_W'(pps_pkg::MAX_SEGMENTS) : pps_pkg::SEGC_W'(seg_count_q);
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pps_pkg::ST_IDLE: begin
				if (accept && (cmd.func == pps_pkg::FUNC_SAMPLE)) begin
					if (!ready_q || (seg_count_q == 5'd0) || (cmd.sample_time == '0)
					    || (cmd.sample_time >= total_q)) begin
						state_d = pps_pkg::ST_DONE;
					end else begin
						state_d = pps_pkg::ST_SEARCH;
					end
				end
			end
			pps_pkg::ST_SEARCH: begin
				if (hit_seg || last_seg) begin
					state_d = pps_pkg::ST_CLAMP;
				end
			end
			pps_pkg::ST_CLAMP:  state_d = pps_pkg::ST_P_RD;
			pps_pkg::ST_P_RD:   state_d = pps_pkg::ST_P_INIT;
			pps_pkg::ST_P_INIT: state_d = pps_pkg::ST_P_HI;
			pps_pkg::ST_P_HI:   state_d = pps_pkg::ST_P_LO;
			pps_pkg::ST_P_LO:   state_d = pps_pkg::ST_P_ADD;
			pps_pkg::ST_P_ADD: begin
				state_d = (term_q == '0) ? pps_pkg::ST_V_RD : pps_pkg::ST_P_HI;
			end
			pps_pkg::ST_V_RD:   state_d = pps_pkg::ST_V_INIT;
			pps_pkg::ST_V_INIT: begin
				state_d = (pps_pkg::NUM_COEFFS > 2) ? pps_pkg::ST_V_HI : pps_pkg::ST_V_END;
			end
			pps_pkg::ST_V_HI:   state_d = pps_pkg::ST_V_LO;
			pps_pkg::ST_V_LO:   state_d = pps_pkg::ST_V_SC;
			pps_pkg::ST_V_SC:   state_d = pps_pkg::ST_V_ADD;
			pps_pkg::ST_V_ADD: begin
				state_d = (term_q == pps_pkg::TERM_W'(1)) ? pps_pkg::ST_V_END : pps_pkg::ST_V_HI;
			end
			pps_pkg::ST_V_END: begin
				state_d = (axis_q == 2'(pps_pkg::NUM_AXES - 1)) ? pps_pkg::ST_DONE
				                                                : pps_pkg::ST_P_RD;
			end
			pps_pkg::ST_DONE:   state_d = pps_pkg::ST_IDLE;
			default:            state_d = pps_pkg::ST_IDLE;
		endcase
	end

	// Output logic: memory reads and arithmetic unit control.
	always_comb begin
		ram_re         = 1'b0;
		rd_term        = term_q;
		mac_ctrl.op    = pps_pkg::MAC_IDLE;
		mac_ctrl.b     = '0;
		mac_ctrl.clr_flag = accept;
		unique case (state_q)
			pps_pkg::ST_P_RD, pps_pkg::ST_V_RD: begin
				ram_re  = 1'b1;
				rd_term = pps_pkg::TERM_W'(pps_pkg::NUM_COEFFS - 1);
			end
			pps_pkg::ST_P_INIT: mac_ctrl.op = pps_pkg::MAC_LOAD;
			pps_pkg::ST_P_HI, pps_pkg::ST_V_HI: begin
				ram_re      = 1'b1;
				mac_ctrl.op = pps_pkg::MAC_HI;
				mac_ctrl.b  = local_q[pps_pkg::TIME_W-1:pps_pkg::HALF_W];
			end
			pps_pkg::ST_P_LO, pps_pkg::ST_V_LO: begin
				mac_ctrl.op = pps_pkg::MAC_LO;
				mac_ctrl.b  = local_q[pps_pkg::HALF_W-1:0];
			end
			pps_pkg::ST_P_ADD:  mac_ctrl.op = pps_pkg::MAC_ADD_C;
			pps_pkg::ST_V_INIT: begin
				mac_ctrl.op = pps_pkg::MAC_SCALE_W;
				mac_ctrl.b  = pps_pkg::HALF_W'(pps_pkg::NUM_COEFFS - 1);
			end
			pps_pkg::ST_V_SC: begin
				mac_ctrl.op = pps_pkg::MAC_SCALE_S;
				mac_ctrl.b  = pps_pkg::HALF_W'(term_q);
			end
			pps_pkg::ST_V_ADD:  mac_ctrl.op = pps_pkg::MAC_ADD_S;
			default: begin
			end
		endcase
		ram_raddr = pps_pkg::COEF_AW'((32'(axis_q) * pps_pkg::MAX_SEGMENTS + 32'(found_q))
		            * pps_pkg::NUM_COEFFS + 32'(rd_term));
	end

	// Coefficient writes from load transactions.
	always_comb begin
		ram_we = accept && (cmd.func == pps_pkg::FUNC_COEF) && (cmd.axis < 2'(pps_pkg::NUM_AXES))
		      && (32'(cmd.segment_index) < pps_pkg::MAX_SEGMENTS)
		      && (32'(cmd.term_index) < pps_pkg::NUM_COEFFS);
		ram_waddr = pps_pkg::COEF_AW'((32'(cmd.axis) * pps_pkg::MAX_SEGMENTS
		            + 32'(cmd.segment_index)) * pps_pkg::NUM_COEFFS + 32'(cmd.term_index));
	end

	pps_coef_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (cmd.load_value),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	pps_mac_unit u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.a      (ram_rdata),
		.w      (mac_w),
		.flag   (mac_flag)
	);

	// Control state and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pps_pkg::ST_IDLE;
			seg_count_q <= 5'd1;
			total_q     <= '0;
			ready_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					pps_pkg::CFG_SEGMENT_COUNT:  seg_count_q <= cfg_data[4:0];
					pps_pkg::CFG_TOTAL_DURATION: total_q <= cfg_data;
					pps_pkg::CFG_TRAJ_READY:     ready_q <= cfg_data[0];
					default: begin
					end
				endcase
			end
		end
	end

	// Duration and endpoint stores.
	always_ff @(posedge clk) begin
		if (accept && (cmd.func == pps_pkg::FUNC_DURATION)
		    && (32'(cmd.segment_index) < pps_pkg::MAX_SEGMENTS)) begin
			dur_q[pps_pkg::SEG_W'(cmd.segment_index)] <= cmd.load_value[pps_pkg::TIME_W-1:0];
		end
		if (accept && (cmd.func == pps_pkg::FUNC_ENDPOINT)
		    && (cmd.axis < 2'(pps_pkg::NUM_AXES))) begin
			endp_q[3'(32'(cmd.endpoint_select) * pps_pkg::NUM_AXES + 32'(cmd.axis))]
				<= cmd.load_value;
		end
	end

	// Sequencer datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			pps_pkg::ST_IDLE: begin
				t_q     <= cmd.sample_time;
				accum_q <= '0;
				idx_q   <= '0;
				axis_q  <= '0;
				n_q     <= n_lim;
				res_q   <= '0;
				if (ready_q && (seg_count_q != 5'd0)) begin
					if (cmd.sample_time == '0) begin
						res_q.sample_ok <= 1'b1;
						res_q.pos_x     <= endp_q[0];
						res_q.pos_y     <= endp_q[1];
						res_q.pos_z     <= endp_q[2];
					end else if (cmd.sample_time >= total_q) begin
						res_q.sample_ok <= 1'b1;
						res_q.pos_x     <= endp_q[3];
						res_q.pos_y     <= endp_q[4];
						res_q.pos_z     <= endp_q[5];
					end
				end
			end
			pps_pkg::ST_SEARCH: begin
				if (hit_seg) begin
					found_q <= idx_q;
					local_q <= pps_pkg::TIME_W'(pps_pkg::SUM_W'(t_q) - accum_q);
				end else if (last_seg) begin
					found_q <= '0;
					local_q <= t_q;
				end else begin
					accum_q <= dur_sum;
					idx_q   <= idx_q + pps_pkg::SEG_W'(1);
				end
			end
			pps_pkg::ST_CLAMP: begin
				if (local_q > dur_rd) begin
					local_q <= dur_rd;
				end
			end
			pps_pkg::ST_P_INIT: term_q <= pps_pkg::TERM_W'(pps_pkg::NUM_COEFFS - 2);
			pps_pkg::ST_P_ADD: begin
				if (term_q != '0) begin
					term_q <= term_q - pps_pkg::TERM_W'(1);
				end
			end
			pps_pkg::ST_V_RD: begin
				unique case (axis_q)
					2'd0:    res_q.pos_x <= mac_w;
					2'd1:    res_q.pos_y <= mac_w;
					default: res_q.pos_z <= mac_w;
				endcase
			end
			pps_pkg::ST_V_INIT: term_q <= pps_pkg::TERM_W'(pps_pkg::NUM_COEFFS - 2);
			pps_pkg::ST_V_ADD: begin
				if (term_q != pps_pkg::TERM_W'(1)) begin
					term_q <= term_q - pps_pkg::TERM_W'(1);
				end
			end
			pps_pkg::ST_V_END: begin
				unique case (axis_q)
					2'd0:    res_q.vel_x <= mac_w;
					2'd1:    res_q.vel_y <= mac_w;
					default: res_q.vel_z <= mac_w;
				endcase
				res_q.sample_ok <= 1'b1;
				res_q.saturated <= mac_flag;
				axis_q <= axis_q + 2'd1;
			end
			default: begin
			end
		endcase
	end

	assign busy   = (state_q != pps_pkg::ST_IDLE);
	assign done   = (state_q == pps_pkg::ST_DONE);
	assign result = res_q;

`ifndef SYNTHESIS
	// A result is followed by a return to idle.
	a_done_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("sampler did not return to idle after a result");

	// Load transactions never occupy the sequencer.
	a_load_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (cmd.func != pps_pkg::FUNC_SAMPLE)) |=> !busy)
		else $error("load transaction made the sampler busy");

	// The search never runs past the segments in use.
	a_search_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pps_pkg::ST_SEARCH) |-> (pps_pkg::SEGC_W'(idx_q) < n_q))
		else $error("segment search past the last segment");

	// An invalid result carries no saturation report.
	a_invalid_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.sample_ok) |-> !result.saturated)
		else $error("saturation reported on an invalid sample");
`endif

endmodule
